// ----- hw/rtl/iehw_pkg.sv -----
// ----------------------------------------------------------------------------
// IPv6 extension header walker package
// Shared types, protocol numbers and the next-header classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package iehw_pkg;

    localparam int QUEUE_DEPTH = 4;

    // Next-header protocol numbers
    localparam logic [7:0] NH_HOPOPT   = 8'd0;
    localparam logic [7:0] NH_ROUTING  = 8'd43;
    localparam logic [7:0] NH_FRAGMENT = 8'd44;
    localparam logic [7:0] NH_AH       = 8'd51;
    localparam logic [7:0] NH_DSTOPTS  = 8'd60;
    localparam logic [7:0] NH_MOBILITY = 8'd135;
    localparam logic [7:0] NH_HIP      = 8'd139;
    localparam logic [7:0] NH_SHIM6    = 8'd140;
    localparam logic [7:0] NH_TEST1    = 8'd253;
    localparam logic [7:0] NH_TEST2    = 8'd254;

    // Base header and jumbo option layout
    localparam logic [15:0] POS_PLEN_HI   = 16'd4;
    localparam logic [15:0] POS_PLEN_LO   = 16'd5;
    localparam logic [15:0] POS_NEXT_HDR  = 16'd6;
    localparam logic [15:0] POS_BASE_LAST = 16'd39;
    localparam logic [15:0] POS_OPT_TYPE  = 16'd42;
    localparam logic [15:0] POS_OPT_LEN   = 16'd43;
    localparam logic [15:0] POS_JUMBO_0   = 16'd44;
    localparam logic [15:0] POS_JUMBO_3   = 16'd47;
    localparam logic [15:0] BASE_HDR_LEN  = 16'd40;
    localparam logic [15:0] OFFSET_MAX    = 16'hFFFF;
    localparam logic [7:0]  OPT_JUMBO     = 8'd194;
    localparam logic [7:0]  OPT_JUMBO_LEN = 8'd4;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_TRUNC = 2'd1,
        STATUS_JUMBO = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_UPPER,
        KIND_EXT,
        KIND_FRAG,
        KIND_AH
    } hdr_kind_t;

    // Classified byte passed from front to back
    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  data;
        logic        last;
        logic        nh_load;
        logic        end_load;
        logic [32:0] end_value;
        logic        jumbo_err;
    } walk_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] header_length;
        logic [7:0]  upper_protocol;
    } walk_result_t;

    function automatic hdr_kind_t hdr_kind(input logic [7:0] nh);
        hdr_kind_t k;
        unique case (nh) inside
            NH_HOPOPT, NH_ROUTING, NH_DSTOPTS, NH_MOBILITY, NH_HIP, NH_SHIM6,
            NH_TEST1, NH_TEST2: k = KIND_EXT;
            NH_FRAGMENT:        k = KIND_FRAG;
            NH_AH:              k = KIND_AH;
            default:            k = KIND_UPPER;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/iehw_front.sv -----
// ----------------------------------------------------------------------------
// IPv6 extension header walker - front end
// Counts byte offsets, collects the payload length and checks the jumbo
// option, tagging each byte for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iehw_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output iehw_pkg::walk_item_t    item
);
    import iehw_pkg::*;

    logic [15:0] offset_reg, offset_next;
    logic [15:0] plen_reg, plen_next;
    logic        nh_zero_reg, nh_zero_next;
    logic        pending_reg, pending_next;
    logic [23:0] acc_reg, acc_next;

    always_comb begin
        logic [15:0] pos;
        logic [31:0] jumbo;
        pos   = offset_reg;
        jumbo = {acc_reg, data_byte};

        item           = '0;
        item.pos       = pos;
        item.data      = data_byte;
        item.last      = last_byte;
        item.nh_load   = (pos == POS_NEXT_HDR);

        offset_next  = (offset_reg == OFFSET_MAX) ? offset_reg : offset_reg + 16'd1;
        plen_next    = plen_reg;
        nh_zero_next = nh_zero_reg;
        pending_next = pending_reg;
        acc_next     = acc_reg;

        if (pos == POS_PLEN_HI) begin
            plen_next[15:8] = data_byte;
        end
        if (pos == POS_PLEN_LO) begin
            plen_next[7:0] = data_byte;
        end
        if (pos == POS_NEXT_HDR) begin
            nh_zero_next = (data_byte == NH_HOPOPT);
        end

        if (pos == POS_BASE_LAST) begin
            if (plen_reg != 16'd0) begin
                item.end_load  = 1'b1;
                item.end_value = {17'd0, BASE_HDR_LEN} + {17'd0, plen_reg};
            end else if (!nh_zero_reg) begin
                item.jumbo_err = 1'b1;
            end else begin
                pending_next = 1'b1;
            end
        end

        // jumbo option must sit first in the hop-by-hop header
        if (pending_reg && pos >= POS_OPT_TYPE && pos <= POS_JUMBO_3) begin
            if (pos == POS_OPT_TYPE) begin
                if (data_byte != OPT_JUMBO) begin
                    item.jumbo_err = 1'b1;
                    pending_next   = 1'b0;
                end
            end else if (pos == POS_OPT_LEN) begin
                if (data_byte != OPT_JUMBO_LEN) begin
                    item.jumbo_err = 1'b1;
                    pending_next   = 1'b0;
                end
            end else if (pos == POS_JUMBO_3) begin
                pending_next = 1'b0;
                if (jumbo == 32'd0) begin
                    item.jumbo_err = 1'b1;
                end else begin
                    item.end_load  = 1'b1;
                    item.end_value = {17'd0, BASE_HDR_LEN} + {1'b0, jumbo};
                end
            end else begin
                acc_next = jumbo[23:0];
            end
        end

        if (pos < POS_JUMBO_0) begin
            acc_next = '0;
        end

        if (last_byte) begin
            offset_next  = '0;
            plen_next    = '0;
            nh_zero_next = 1'b0;
            pending_next = 1'b0;
            acc_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            plen_reg    <= '0;
            nh_zero_reg <= 1'b0;
            pending_reg <= 1'b0;
            acc_reg     <= '0;
        end else if (accept) begin
            offset_reg  <= offset_next;
            plen_reg    <= plen_next;
            nh_zero_reg <= nh_zero_next;
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/iehw_queue.sv -----
// ----------------------------------------------------------------------------
// IPv6 extension header walker - item queue
// Short first-in first-out queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iehw_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               wr_en,
    input  iehw_pkg::walk_item_t    wr_item,
    output logic                    full,
    input  wire logic               rd_en,
    output iehw_pkg::walk_item_t    rd_item,
    output logic                    not_empty
);
    import iehw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    walk_item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/iehw_back.sv -----
// ----------------------------------------------------------------------------
// IPv6 extension header walker - back end
// Walks the extension header chain one header step per byte and holds
// the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iehw_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  iehw_pkg::walk_item_t    in_item,
    output logic                    in_take,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output iehw_pkg::walk_result_t  out_result
);
    import iehw_pkg::*;

    localparam logic [16:0] SAT_LIMIT = 17'd65535;

    logic [15:0]   hs_reg, hs_next;
    logic [7:0]    cnh_reg, cnh_next;
    logic [7:0]    ext_nb_reg, ext_nb_next;
    logic [7:0]    ext_lb_reg, ext_lb_next;
    logic [32:0]   pe_reg, pe_next;
    logic          pe_known_reg, pe_known_next;
    logic          decided_reg, decided_next;
    logic          out_valid_reg, out_valid_next;
    walk_result_t  out_res_reg, out_res_next;

    assign in_take    = in_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_res_reg;

    always_comb begin
        logic [7:0]   cnh;
        logic [7:0]   nb;
        logic [7:0]   lb;
        logic [32:0]  pe;
        logic         known;
        logic         emit;
        walk_result_t res;
        hdr_kind_t    kind;
        logic         ready_adv;
        logic [8:0]   lb_plus2;
        logic [16:0]  ns;

        hs_next        = hs_reg;
        cnh_next       = cnh_reg;
        ext_nb_next    = ext_nb_reg;
        ext_lb_next    = ext_lb_reg;
        pe_next        = pe_reg;
        pe_known_next  = pe_known_reg;
        decided_next   = decided_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        cnh      = in_item.nh_load ? in_item.data : cnh_reg;
        nb       = (in_item.pos == hs_reg) ? in_item.data : ext_nb_reg;
        lb       = ({1'b0, in_item.pos} == {1'b0, hs_reg} + 17'd1) ? in_item.data
                                                                    : ext_lb_reg;
        pe       = in_item.end_load ? in_item.end_value : pe_reg;
        known    = pe_known_reg || in_item.end_load;
        kind     = hdr_kind(cnh);
        lb_plus2 = {1'b0, lb} + 9'd2;
        emit     = 1'b0;
        res      = '0;
        ns       = '0;

        unique case (kind)
            KIND_FRAG: begin
                ready_adv = (in_item.pos >= hs_reg);
                ns        = {1'b0, hs_reg} + 17'd8;
            end
            KIND_AH: begin
                ready_adv = (in_item.pos > hs_reg);
                ns        = {1'b0, hs_reg} + {6'd0, lb_plus2, 2'b00};
            end
            KIND_EXT: begin
                ready_adv = (in_item.pos > hs_reg);
                ns        = {1'b0, hs_reg} + {6'd0, lb, 3'b000} + 17'd8;
            end
            default: begin
                ready_adv = 1'b0;
            end
        endcase

        if (in_take && !decided_reg) begin
            cnh_next      = cnh;
            ext_nb_next   = nb;
            ext_lb_next   = lb;
            pe_next       = pe;
            pe_known_next = known;

            if (in_item.jumbo_err) begin
                emit       = 1'b1;
                res.status = STATUS_JUMBO;
            end else if (known) begin
                if ({17'd0, hs_reg} >= pe || kind == KIND_UPPER) begin
                    emit               = 1'b1;
                    res.upper_protocol = cnh;
                    res.header_length  = hs_reg;
                    res.status         = STATUS_OK;
                end else if (ready_adv) begin
                    // step over this header, then look at the next one
                    cnh_next = nb;
                    if (ns >= SAT_LIMIT) begin
                        emit               = 1'b1;
                        res.upper_protocol = nb;
                        res.header_length  = SAT_LIMIT[15:0];
                        res.status         = STATUS_OK;
                    end else begin
                        hs_next = ns[15:0];
                        if ({16'd0, ns} >= pe || hdr_kind(nb) == KIND_UPPER) begin
                            emit               = 1'b1;
                            res.upper_protocol = nb;
                            res.header_length  = ns[15:0];
                            res.status         = STATUS_OK;
                        end
                    end
                end
            end

            if (in_item.last && !emit) begin
                emit       = 1'b1;
                res        = '0;
                res.status = STATUS_TRUNC;
            end

            if (emit) begin
                decided_next   = 1'b1;
                out_valid_next = 1'b1;
                out_res_next   = res;
            end
        end

        // drop all packet state at the end of the packet
        if (in_take && in_item.last) begin
            hs_next       = BASE_HDR_LEN;
            cnh_next      = '0;
            ext_nb_next   = '0;
            ext_lb_next   = '0;
            pe_next       = '0;
            pe_known_next = 1'b0;
            decided_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hs_reg        <= BASE_HDR_LEN;
            cnh_reg       <= '0;
            ext_nb_reg    <= '0;
            ext_lb_reg    <= '0;
            pe_reg        <= '0;
            pe_known_reg  <= 1'b0;
            decided_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            hs_reg        <= hs_next;
            cnh_reg       <= cnh_next;
            ext_nb_reg    <= ext_nb_next;
            ext_lb_reg    <= ext_lb_next;
            pe_reg        <= pe_next;
            pe_known_reg  <= pe_known_next;
            decided_reg   <= decided_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ipv6_ext_header_walker.sv -----
// ----------------------------------------------------------------------------
// IPv6 extension header walker
// Finds the upper-layer protocol and its offset in a byte-wide IPv6 packet.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the packet one byte per item, base header byte 0 first,
//   with s_axis_tlast on the final byte. m_axis gives one result per packet:
//   upper protocol, header length (saturated at 65535) and status
//   (ok, packet ended early, unsupported jumbo layout).
//   Throughput is one byte per cycle while no result waits on m_axis_tready:
//   the back end takes one queued byte each cycle and advances the chain by
//   at most one header per byte. The deciding byte passes through the queue
//   and then the result register before m_axis_tvalid rises.
//   A four-entry queue between front and back end and the result register
//   let s_axis keep flowing while a result waits; when the queue fills,
//   s_axis_tready drops until m_axis_tready takes the result.
//   Reset (aresetn low, synchronous) empties the queue, drops any waiting
//   result and restarts at byte 0 of a new packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_ext_header_walker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [7:0] upper_protocol,
                                             // [23:8] header_length,
                                             // [25:24] status, [31:26] zero
);
    import iehw_pkg::*;

    walk_item_t   front_item;
    walk_item_t   back_item;
    walk_result_t result;
    logic         queue_full;
    logic         queue_not_empty;
    logic         back_take;
    logic         s_accept;

    assign s_axis_tready = !queue_full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    iehw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .item      (front_item)
    );

    iehw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (s_accept),
        .wr_item   (front_item),
        .full      (queue_full),
        .rd_en     (back_take),
        .rd_item   (back_item),
        .not_empty (queue_not_empty)
    );

    iehw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (queue_not_empty),
        .in_item    (back_item),
        .in_take    (back_take),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {6'd0, result.status, result.header_length,
                           result.upper_protocol};

endmodule

`default_nettype wire
